// ===== rtl/core/ppw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ppw_pkg;

	localparam int NUM_AXES    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int AXIS_MASK_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_X_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_X_HIGH    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y_LOW     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y_HIGH    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_Z_LOW     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_Z_HIGH    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_AXIS_PERIODIC = 3'd6;

	// High edge after reset is 16.0 in Q16.16.
	localparam longint BOX_HIGH_RESET = 1048576;
	localparam logic [AXIS_MASK_W-1:0] PERIODIC_RESET = 3'b111;

	typedef struct packed {
		logic active;
		logic above;
	} wrap_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/periodic_position_wrap.sv =====
// A word accepted at the input passes the front stage, the COORD_WIDTH division
// stages, the finish stage and the output register. Throughput: one word per cycle
// while out_ready is high. Each axis has a restoring divider that resolves one
// quotient bit per pipeline stage, which sets the depth of COORD_WIDTH division stages.
// Reset clears the valid bits of every stage and loads the box registers with their
// reset values; the pipeline is empty and ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module periodic_position_wrap #(
	parameter int COORD_WIDTH = 32,
	parameter int IMAGE_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ppw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [COORD_WIDTH-1:0]          cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]   pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]   pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]   pos_z,
	input  wire logic signed [IMAGE_WIDTH-1:0]   image_x,
	input  wire logic signed [IMAGE_WIDTH-1:0]   image_y,
	input  wire logic signed [IMAGE_WIDTH-1:0]   image_z,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [COORD_WIDTH-1:0]        wrapped_x,
	output logic signed [COORD_WIDTH-1:0]        wrapped_y,
	output logic signed [COORD_WIDTH-1:0]        wrapped_z,
	output logic signed [IMAGE_WIDTH-1:0]        new_image_x,
	output logic signed [IMAGE_WIDTH-1:0]        new_image_y,
	output logic signed [IMAGE_WIDTH-1:0]        new_image_z
);
	import ppw_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int IW = IMAGE_WIDTH;
	localparam int SW = ((CW > IW) ? CW : IW) + 2;

	localparam logic [CW-1:0] HIGH_RST = CW'(BOX_HIGH_RESET);
	localparam logic [SW-1:0] IMG_MAX  = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
	localparam logic [SW-1:0] IMG_MIN  = {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}};

	// One axis in flight. For an axis that does not wrap, dq carries the coordinate
	// through unchanged; otherwise it holds the dividend bits still to be consumed at
	// the top and the quotient bits already found at the bottom.
	typedef struct packed {
		logic [CW-1:0] rem;
		logic [CW-1:0] dq;
		logic [CW-1:0] size;
		logic [IW-1:0] img;
		wrap_ctl_t     ctl;
	} lane_t;

	typedef struct packed {
		logic [CW-1:0] xo;
		logic [SW-1:0] sum;
	} fin_t;

	logic [CW-1:0]          box_low_q  [NUM_AXES];
	logic [CW-1:0]          box_high_q [NUM_AXES];
	logic [AXIS_MASK_W-1:0] periodic_q;

	logic [CW-1:0] pos_in [NUM_AXES];
	logic [IW-1:0] img_in [NUM_AXES];

	logic  v_s1;
	lane_t lane_s1 [NUM_AXES];
	logic  en_s1;

	logic  v_sd    [CW];
	lane_t lane_sd [CW][NUM_AXES];
	logic  en_sd   [CW];

	logic v_sf;
	fin_t fin_sf [NUM_AXES];
	logic en_sf;

	logic          v_so;
	logic [CW-1:0] wrapped_so [NUM_AXES];
	logic [IW-1:0] image_so   [NUM_AXES];
	logic          en_so;

	function automatic lane_t front_lane(input logic [CW-1:0] x, input logic [IW-1:0] img,
		input logic [CW-1:0] lo, input logic [CW-1:0] hi, input logic per);
		logic [CW:0] size_w;
		logic [CW:0] dif_hi;
		logic [CW:0] dif_lo;
		logic        above;
		logic        below;
		logic        pos;
		lane_t       l;
		size_w = {hi[CW-1], hi} - {lo[CW-1], lo};
		dif_hi = {x[CW-1], x} - {hi[CW-1], hi};
		dif_lo = {lo[CW-1], lo} - {x[CW-1], x};
		above  = $signed(x) > $signed(hi);
		below  = $signed(x) < $signed(lo);
		pos    = !size_w[CW] && (size_w != '0);
		l.ctl.active = per && pos && (above || below);
		l.ctl.above  = above;
		l.rem  = '0;
		l.size = size_w[CW-1:0];
		l.img  = img;
		if (!l.ctl.active) begin
			l.dq = x;
		end else if (above) begin
			l.dq = dif_hi[CW-1:0];
		end else begin
			l.dq = dif_lo[CW-1:0];
		end
		return l;
	endfunction

	// One step of restoring division: bring down the next dividend bit and
	// subtract the size where it fits.
	function automatic lane_t div_step(input lane_t l);
		logic [CW:0] trial;
		logic [CW:0] diffv;
		lane_t       r;
		r     = l;
		trial = {l.rem, l.dq[CW-1]};
		diffv = trial - {1'b0, l.size};
		if (l.ctl.active) begin
			if (!diffv[CW]) begin
				r.rem = diffv[CW-1:0];
				r.dq  = {l.dq[CW-2:0], 1'b1};
			end else begin
				r.rem = trial[CW-1:0];
				r.dq  = {l.dq[CW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic fin_t finish_lane(input lane_t l, input logic [CW-1:0] lo,
		input logic [CW-1:0] hi);
		logic [SW-1:0] img_e;
		logic [SW-1:0] q_e;
		fin_t          f;
		img_e = SW'($signed(l.img));
		q_e   = SW'(l.dq);
		if (!l.ctl.active) begin
			f.xo  = l.dq;
			f.sum = img_e;
		end else if (l.ctl.above) begin
			f.xo  = lo + l.rem;
			f.sum = img_e + q_e + SW'(1);
		end else begin
			// img - (q + 1) is img plus the complement of q.
			f.xo  = hi - l.rem;
			f.sum = img_e + ~q_e;
		end
		return f;
	endfunction

	function automatic logic [IW-1:0] sat_image(input logic [SW-1:0] s);
		logic [IW-1:0] r;
		if ($signed(s) > $signed(IMG_MAX)) begin
			r = IMG_MAX[IW-1:0];
		end else if ($signed(s) < $signed(IMG_MIN)) begin
			r = IMG_MIN[IW-1:0];
		end else begin
			r = s[IW-1:0];
		end
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_low_q[a]  <= '0;
				box_high_q[a] <= HIGH_RST;
			end
			periodic_q <= PERIODIC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_X_LOW:     box_low_q[0]  <= cfg_data;
				REG_BOX_X_HIGH:    box_high_q[0] <= cfg_data;
				REG_BOX_Y_LOW:     box_low_q[1]  <= cfg_data;
				REG_BOX_Y_HIGH:    box_high_q[1] <= cfg_data;
				REG_BOX_Z_LOW:     box_low_q[2]  <= cfg_data;
				REG_BOX_Z_HIGH:    box_high_q[2] <= cfg_data;
				REG_AXIS_PERIODIC: periodic_q    <= cfg_data[AXIS_MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign img_in[0] = image_x;
	assign img_in[1] = image_y;
	assign img_in[2] = image_z;

	// A stage takes a new word when it is empty or when its word moves on.
	assign en_so    = !v_so || out_ready;
	assign en_sf    = !v_sf || en_so;
	assign en_s1    = !v_s1 || en_sd[0];
	assign in_ready = en_s1;

	// Front stage: edge compares, size and the distance past the edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				lane_s1[a] <= front_lane(pos_in[a], img_in[a], box_low_q[a], box_high_q[a],
					periodic_q[a]);
			end
		end
	end

	// Division stages, one quotient bit each.
	for (genvar k = 0; k < CW; k++) begin : g_div
		if (k == CW - 1) begin : g_last
			assign en_sd[k] = !v_sd[k] || en_sf;
		end else begin : g_mid
			assign en_sd[k] = !v_sd[k] || en_sd[k+1];
		end

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sd[k] <= 1'b0;
				end else if (en_sd[k]) begin
					v_sd[k] <= v_s1;
				end
			end

			always_ff @(posedge clk) begin
				if (en_sd[k]) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						lane_sd[k][a] <= div_step(lane_s1[a]);
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sd[k] <= 1'b0;
				end else if (en_sd[k]) begin
					v_sd[k] <= v_sd[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en_sd[k]) begin
					for (int a = 0; a < NUM_AXES; a++) begin
						lane_sd[k][a] <= div_step(lane_sd[k-1][a]);
					end
				end
			end
		end
	end

	// Fold the remainder back into the box and form the raw image counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en_sf) begin
			v_sf <= v_sd[CW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_sf) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				fin_sf[a] <= finish_lane(lane_sd[CW-1][a], box_low_q[a], box_high_q[a]);
			end
		end
	end

	// Output register with image count saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (en_so) begin
			v_so <= v_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (en_so) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				wrapped_so[a] <= fin_sf[a].xo;
				image_so[a]   <= sat_image(fin_sf[a].sum);
			end
		end
	end

	assign out_valid   = v_so;
	assign wrapped_x   = wrapped_so[0];
	assign wrapped_y   = wrapped_so[1];
	assign wrapped_z   = wrapped_so[2];
	assign new_image_x = image_so[0];
	assign new_image_y = image_so[1];
	assign new_image_z = image_so[2];

	// The input side only stalls when the whole pipeline is backed up behind the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready && v_s1 && v_sf))
		else $error("input stalled while the pipeline has room");

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_chk
		// A wrapping axis always starts with a nonzero distance past the edge.
		assert property (@(posedge clk) disable iff (!arst_n)
			(v_s1 && lane_s1[a].ctl.active) |-> (lane_s1[a].dq != '0))
			else $error("wrapping axis with zero distance");

		// The division leaves a remainder below the box size.
		assert property (@(posedge clk) disable iff (!arst_n)
			(v_sd[CW-1] && lane_sd[CW-1][a].ctl.active) |->
			(lane_sd[CW-1][a].rem < lane_sd[CW-1][a].size))
			else $error("division remainder not below box size");
	end

endmodule

`default_nettype wire
